// ===== rtl/positional_linked_list_engine_core_macros.svh =====
// Assertion macros for the positional linked-list engine checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef POSITIONAL_LINKED_LIST_ENGINE_CORE_MACROS_SVH
`define POSITIONAL_LINKED_LIST_ENGINE_CORE_MACROS_SVH

// Generic clocked assertion, disabled while reset is asserted (active low).
`define PLLE_ASSERT_CLK(lbl, clk_s, rst_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
		else $error(msg);

// Shorthand on the block clock and reset.
`define PLLE_ASSERT(lbl, prop, msg) \
	`PLLE_ASSERT_CLK(lbl, clk, arst_n, prop, msg)

`endif

// ===== rtl/plle_pkg.sv =====
// Shared types, constants and helpers for the positional linked-list engine.
// No dependencies.
`default_nettype none

package plle_pkg;

	localparam int CAPACITY   = 64;
	localparam int VALUE_BITS = 32;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int CMD_W      = 3;
	localparam int POS_W      = 7;
	localparam int STS_W      = 2;
	localparam int CMP_W      = (POS_W > CNT_W) ? POS_W : CNT_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_GET    = 3'd0,
		CMD_INSERT = 3'd1,
		CMD_DELETE = 3'd2,
		CMD_PUSH   = 3'd3,
		CMD_APPEND = 3'd4,
		CMD_CLEAR  = 3'd5
	} plle_cmd_t;

	typedef enum logic [STS_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} plle_status_t;

	typedef struct packed {
		logic [CMD_W-1:0]             command;
		logic [POS_W-1:0]             position;
		logic signed [VALUE_BITS-1:0] value;
	} plle_req_t;

	typedef struct packed {
		logic [STS_W-1:0]             status;
		logic signed [VALUE_BITS-1:0] data;
		logic [CNT_W-1:0]             count;
	} plle_rsp_t;

	// controller -> datapath step strobes
	typedef struct packed {
		logic latch;
		logic check;
		logic clear;
		logic take;
		logic taken;
		logic wstart;
		logic walk;
		logic wdone;
		logic dhead;
		logic dnext;
		logic dfree;
		logic ilink;
		logic lnew;
		logic app;
	} plle_ctl_t;

	// datapath -> controller status
	typedef struct packed {
		logic is_get;
		logic is_ins;
		logic is_del;
		logic is_push;
		logic is_app;
		logic is_clr;
		logic err;
		logic pos_one;
		logic walk_zero;
		logic walk_last;
	} plle_sts_t;

	// free chain successor of a node after reset or clear
	function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] a);
		next_idx = (a == IDX_W'(CAPACITY - 1)) ? '0 : a + IDX_W'(1);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/plle_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module plle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/plle_ctrl.sv =====
// Command sequencer for the positional linked-list engine.
// Depends on plle_pkg.
`default_nettype none

module plle_ctrl
	import plle_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire plle_sts_t sts,
	output      plle_ctl_t ctl,
	output      logic      busy,
	output      logic      done
);

	typedef enum logic [13:0] {
		S_IDLE   = 14'h0001,
		S_CHECK  = 14'h0002,
		S_TAKE   = 14'h0004,
		S_TAKEN  = 14'h0008,
		S_WSTART = 14'h0010,
		S_WALK   = 14'h0020,
		S_WDONE  = 14'h0040,
		S_ILINK  = 14'h0080,
		S_DHEAD  = 14'h0100,
		S_DNEXT  = 14'h0200,
		S_DFREE  = 14'h0400,
		S_LNEW   = 14'h0800,
		S_APP    = 14'h1000,
		S_RESP   = 14'h2000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.latch = 1'b1;
					state_d   = S_CHECK;
				end
			end
			S_CHECK: begin
				ctl.check = 1'b1;
				if (sts.err) begin
					state_d = S_RESP;
				end else if (sts.is_clr) begin
					ctl.clear = 1'b1;
					state_d   = S_RESP;
				end else if (sts.is_get) begin
					state_d = S_WSTART;
				end else if (sts.is_del) begin
					state_d = sts.pos_one ? S_DHEAD : S_WSTART;
				end else if (sts.is_ins || sts.is_push || sts.is_app) begin
					state_d = S_TAKE;
				end else begin
					state_d = S_RESP;
				end
			end
			S_TAKE: begin
				ctl.take = 1'b1;
				state_d  = S_TAKEN;
			end
			S_TAKEN: begin
				ctl.taken = 1'b1;
				if (sts.is_ins && !sts.pos_one) begin
					state_d = S_WSTART;
				end else if (sts.is_ins || sts.is_push) begin
					state_d = S_LNEW;
				end else begin
					state_d = S_APP;
				end
			end
			S_WSTART: begin
				ctl.wstart = 1'b1;
				state_d    = sts.walk_zero ? S_WDONE : S_WALK;
			end
			S_WALK: begin
				ctl.walk = 1'b1;
				if (sts.walk_last) begin
					state_d = S_WDONE;
				end
			end
			S_WDONE: begin
				ctl.wdone = 1'b1;
				if (sts.is_ins) begin
					state_d = S_ILINK;
				end else if (sts.is_del) begin
					state_d = S_DNEXT;
				end else begin
					state_d = S_RESP;
				end
			end
			S_ILINK: begin
				ctl.ilink = 1'b1;
				state_d   = S_RESP;
			end
			S_DHEAD: begin
				ctl.dhead = 1'b1;
				state_d   = S_DNEXT;
			end
			S_DNEXT: begin
				ctl.dnext = 1'b1;
				state_d   = S_DFREE;
			end
			S_DFREE: begin
				ctl.dfree = 1'b1;
				state_d   = S_RESP;
			end
			S_LNEW: begin
				ctl.lnew = 1'b1;
				state_d  = S_RESP;
			end
			S_APP: begin
				ctl.app = 1'b1;
				state_d = S_RESP;
			end
			S_RESP: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_RESP);

endmodule

`default_nettype wire

// ===== rtl/plle_dp.sv =====
// Datapath of the positional linked-list engine: list pointers, link and
// value stores, walker and result registers. Depends on plle_pkg, plle_ram.
`default_nettype none

module plle_dp
	import plle_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire plle_req_t request,
	input  wire plle_ctl_t ctl,
	output      plle_sts_t sts,
	output      plle_rsp_t result
);

	// latched transaction
	logic [CMD_W-1:0]             cmd_q;
	logic [POS_W-1:0]             pos_q;
	logic signed [VALUE_BITS-1:0] val_q;

	// list state
	logic [IDX_W-1:0] head_q, tail_q, free_q;
	logic [CNT_W-1:0] count_q;
	logic [CAPACITY-1:0] lvalid_q;   // link entry written since last clear

	// walker / scratch
	logic [IDX_W-1:0] cur_q;         // walk position, later the predecessor
	logic [IDX_W-1:0] node_q;        // taken or removed node
	logic [IDX_W-1:0] steps_q;

	// result
	logic [STS_W-1:0]             status_q;
	logic signed [VALUE_BITS-1:0] data_q;

	// link read tracking
	logic [IDX_W-1:0] rd_addr_s1;
	logic             rd_vld_s1;

	logic                  l_we, l_re;
	logic [IDX_W-1:0]      l_waddr, l_wdata, l_raddr, l_rdata;
	logic                  v_we;
	logic [VALUE_BITS-1:0] v_rdata;
	logic [IDX_W-1:0]      link_eff;

	logic                  need_pos, need_node, range_bad, full;
	logic                  count_zero, count_one, pos_is_count;
	logic [CMP_W-1:0]      pos_w, cnt_w;
	logic [POS_W-1:0]      steps_full;
	logic [IDX_W-1:0]      steps_init;
	plle_status_t          st_calc;

	// ---- decode ----
	assign sts.is_get  = (cmd_q == CMD_GET);
	assign sts.is_ins  = (cmd_q == CMD_INSERT);
	assign sts.is_del  = (cmd_q == CMD_DELETE);
	assign sts.is_push = (cmd_q == CMD_PUSH);
	assign sts.is_app  = (cmd_q == CMD_APPEND);
	assign sts.is_clr  = (cmd_q == CMD_CLEAR);

	assign pos_w        = CMP_W'(pos_q);
	assign cnt_w        = CMP_W'(count_q);
	assign need_pos     = sts.is_get || sts.is_ins || sts.is_del;
	assign need_node    = sts.is_ins || sts.is_push || sts.is_app;
	assign range_bad    = (pos_q == '0) || (pos_w > cnt_w);
	assign full         = (count_q >= CNT_W'(CAPACITY));
	assign count_zero   = (count_q == '0);
	assign count_one    = (count_q == CNT_W'(1));
	assign pos_is_count = (pos_w == cnt_w);

	always_comb begin
		if (need_pos && range_bad) begin
			st_calc = ST_RANGE;
		end else if (need_node && full) begin
			st_calc = ST_FULL;
		end else begin
			st_calc = ST_OK;
		end
	end

	// get walks to pos, insert/delete walk to pos-1
	assign steps_full = pos_q - (sts.is_get ? POS_W'(1) : POS_W'(2));
	assign steps_init = IDX_W'(steps_full);

	assign sts.err       = (st_calc != ST_OK);
	assign sts.pos_one   = (pos_q == POS_W'(1));
	assign sts.walk_zero = (steps_init == '0);
	assign sts.walk_last = (steps_q == IDX_W'(1));

	// unwritten link entries read as the reset free chain
	assign link_eff = rd_vld_s1 ? l_rdata : next_idx(rd_addr_s1);

	// ---- link / value store ports ----
	assign l_re = ctl.take || ctl.wstart || ctl.walk || ctl.dhead ||
		(ctl.wdone && sts.is_del);

	always_comb begin
		if (ctl.take) begin
			l_raddr = free_q;
		end else if (ctl.wstart || ctl.dhead) begin
			l_raddr = head_q;
		end else begin
			l_raddr = link_eff;
		end
	end

	always_comb begin
		l_we    = 1'b0;
		l_waddr = node_q;
		l_wdata = '0;
		if (ctl.wdone && sts.is_ins) begin
			l_we    = 1'b1;
			l_wdata = link_eff;
		end else if (ctl.ilink) begin
			l_we    = 1'b1;
			l_waddr = cur_q;
			l_wdata = node_q;
		end else if (ctl.dnext && !sts.pos_one) begin
			l_we    = 1'b1;
			l_waddr = cur_q;
			l_wdata = link_eff;
		end else if (ctl.dfree) begin
			l_we    = 1'b1;
			l_wdata = free_q;
		end else if (ctl.lnew) begin
			l_we    = 1'b1;
			l_wdata = head_q;
		end else if (ctl.app && !count_zero) begin
			l_we    = 1'b1;
			l_waddr = tail_q;
			l_wdata = node_q;
		end
	end

	assign v_we = ctl.take;

	plle_ram #(
		.WIDTH(IDX_W),
		.DEPTH(CAPACITY)
	) u_link_ram (
		.clk   (clk),
		.we    (l_we),
		.waddr (l_waddr),
		.wdata (l_wdata),
		.re    (l_re),
		.raddr (l_raddr),
		.rdata (l_rdata)
	);

	plle_ram #(
		.WIDTH(VALUE_BITS),
		.DEPTH(CAPACITY)
	) u_value_ram (
		.clk   (clk),
		.we    (v_we),
		.waddr (free_q),
		.wdata (val_q),
		.re    (l_re),
		.raddr (l_raddr),
		.rdata (v_rdata)
	);

	// ---- control registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			free_q   <= '0;
			count_q  <= '0;
			lvalid_q <= '0;
		end else begin
			if (ctl.clear) begin
				head_q   <= '0;
				tail_q   <= '0;
				free_q   <= '0;
				count_q  <= '0;
				lvalid_q <= '0;
			end else begin
				if (l_we) begin
					lvalid_q[l_waddr] <= 1'b1;
				end
				if (ctl.taken) begin
					free_q <= link_eff;
				end
				if (ctl.ilink) begin
					count_q <= count_q + CNT_W'(1);
				end
				if (ctl.dnext) begin
					if (sts.pos_one) begin
						head_q <= link_eff;
					end
					if (pos_is_count) begin
						tail_q <= cur_q;
					end
				end
				if (ctl.dfree) begin
					free_q  <= node_q;
					count_q <= count_q - CNT_W'(1);
					if (count_one) begin
						head_q <= '0;
						tail_q <= '0;
					end
				end
				if (ctl.lnew) begin
					head_q  <= node_q;
					count_q <= count_q + CNT_W'(1);
					if (sts.is_push && count_zero) begin
						tail_q <= node_q;
					end
				end
				if (ctl.app) begin
					if (count_zero) begin
						head_q <= node_q;
					end
					tail_q  <= node_q;
					count_q <= count_q + CNT_W'(1);
				end
			end
		end
	end

	// ---- payload registers ----
	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			cmd_q <= request.command;
			pos_q <= request.position;
			val_q <= request.value;
		end
		if (l_re) begin
			rd_addr_s1 <= l_raddr;
			rd_vld_s1  <= lvalid_q[l_raddr];
		end
		if (ctl.check) begin
			status_q <= st_calc;
			data_q   <= '0;
		end
		if (ctl.take) begin
			node_q <= free_q;
		end
		if (ctl.wstart) begin
			cur_q   <= head_q;
			steps_q <= steps_init;
		end
		if (ctl.walk) begin
			cur_q   <= link_eff;
			steps_q <= steps_q - IDX_W'(1);
		end
		if (ctl.wdone) begin
			if (sts.is_get) begin
				data_q <= v_rdata;
			end
			if (sts.is_del) begin
				node_q <= link_eff;
			end
		end
		if (ctl.dhead) begin
			node_q <= head_q;
			cur_q  <= '0;
		end
		if (ctl.dnext) begin
			data_q <= v_rdata;
		end
	end

	assign result.status = status_q;
	assign result.data   = data_q;
	assign result.count  = count_q;

endmodule

`default_nettype wire

// ===== rtl/positional_linked_list_engine_core.sv =====
// Top level of the positional linked-list engine: sequencer plus datapath.
// Depends on plle_pkg, plle_ctrl, plle_dp (and plle_ram through plle_dp).
//
// Channel   Ports                 Handshake                 Payload
// command   start, busy, request  start && !busy at clk     plle_req_t
// result    done, result          done, one cycle, no stall plle_rsp_t
//
// Steps: each transaction has a common setup (accept, check, response)
// plus work that depends on the command. Get walks pos-1 links, insert and
// delete beyond the head walk pos-2 links, one link per cycle out of the
// link RAM's registered read port. A delete at the tail of a full list, or an
// insert just before the tail of a 63-entry list, makes the longest transaction.
// Push, append, clear and errors walk no links.
// Reset: head, tail, free pointer and count go to zero and every link entry
// reads as the chained free list; clear does the same.
// Stalls: busy is high from the accepting edge through the done cycle and
// low in the cycle after; the receiver takes done/result in that one cycle
// and cannot hold it off.
`default_nettype none

module positional_linked_list_engine_core
	import plle_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire plle_req_t request,
	output      logic      busy,
	output      logic      done,
	output      plle_rsp_t result
);

	plle_ctl_t ctl;   // step strobes driven by the sequencer states
	plle_sts_t sts;   // decoded command and walk status

	// Sequencer: one-hot FSM, walks the command through its memory steps.
	plle_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done)
	);

	// Datapath: node stores, list pointers, walker and result registers.
	plle_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.ctl     (ctl),
		.sts     (sts),
		.result  (result)
	);

endmodule

`default_nettype wire

// ===== rtl/plle_checker.sv =====
// Port-level checker for the positional linked-list engine, bound to the top.
// Depends on plle_pkg and positional_linked_list_engine_core_macros.svh.
`default_nettype none

`include "positional_linked_list_engine_core_macros.svh"

module plle_checker
	import plle_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      start,
	input wire plle_req_t request,
	input wire logic      busy,
	input wire logic      done,
	input wire plle_rsp_t result
);

	`PLLE_ASSERT(a_done_while_busy, done |-> busy, "result strobe outside a transaction")
	`PLLE_ASSERT(a_accept_sets_busy, (start && !busy) |=> busy, "accepted command did not go busy")
	`PLLE_ASSERT(a_done_single, done |=> !done, "result strobe longer than one cycle")
	`PLLE_ASSERT(a_err_zero_data, (done && result.status != ST_OK) |-> (result.data == '0), "error result with data")
	`PLLE_ASSERT(a_count_bound, done |-> (result.count <= CNT_W'(CAPACITY)), "count beyond capacity")

endmodule

bind positional_linked_list_engine_core plle_checker u_plle_checker (.*);

`default_nettype wire

// ===== tb/sv/positional_linked_list_engine_core_chk.sv =====
// Scoreboard for the positional linked-list engine: mirrors the node store,
// predicts one response per accepted command and checks each done strobe.
// Depends on plle_pkg.
module positional_linked_list_engine_core_chk
	import plle_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  plle_req_t         request,
	input  logic              done,
	input  plle_rsp_t         result,
	output int unsigned       mismatch_count,
	output int unsigned       answers_due,
	output logic [CNT_W-1:0]  list_len
);

	// shadow node store; values stay unknown until a node is claimed
	logic signed [VALUE_BITS-1:0] node_val [CAPACITY];
	logic [IDX_W-1:0]             node_nxt [CAPACITY];
	logic [IDX_W-1:0]             head_ptr, tail_ptr, free_ptr;
	logic [CNT_W-1:0]             elem_cnt;

	plle_rsp_t answer_q [$];
	plle_rsp_t due_now, fresh;

	task automatic rebuild_free_chain();
		for (int k = 0; k < CAPACITY; k++)
			node_nxt[k] = IDX_W'((k + 1) % CAPACITY);
		free_ptr = '0;
		head_ptr = '0;
		tail_ptr = '0;
		elem_cnt = '0;
	endtask

	function automatic logic [IDX_W-1:0] claim_node(input logic signed [VALUE_BITS-1:0] v);
		logic [IDX_W-1:0] n;
		n = free_ptr;
		free_ptr = node_nxt[n];
		node_val[n] = v;
		return n;
	endfunction

	// node index at a 1-based position; caller has checked the range
	function automatic logic [IDX_W-1:0] node_at(input logic [POS_W-1:0] pos);
		logic [IDX_W-1:0] n;
		n = head_ptr;
		for (int k = 1; k < pos; k++)
			n = node_nxt[n];
		return n;
	endfunction

	task automatic run_list_command(input plle_req_t r, output plle_rsp_t a);
		plle_status_t                 st;
		logic signed [VALUE_BITS-1:0] d;
		logic                         pos_ok, full;
		logic [IDX_W-1:0]             n, p;
		st     = ST_OK;
		d      = '0;
		n      = '0;
		p      = '0;
		pos_ok = (r.position != 0) && (r.position <= elem_cnt);
		full   = (elem_cnt >= CAPACITY);
		case (r.command)
			CMD_GET: begin
				if (!pos_ok)
					st = ST_RANGE;
				else
					d = node_val[node_at(r.position)];
			end
			CMD_INSERT: begin
				if (!pos_ok) begin
					st = ST_RANGE;
				end else if (full) begin
					st = ST_FULL;
				end else begin
					n = claim_node(r.value);
					if (r.position == 1) begin
						node_nxt[n] = head_ptr;
						head_ptr    = n;
					end else begin
						p           = node_at(r.position - 1'b1);
						node_nxt[n] = node_nxt[p];
						node_nxt[p] = n;
					end
					elem_cnt++;
				end
			end
			CMD_DELETE: begin
				if (!pos_ok) begin
					st = ST_RANGE;
				end else begin
					if (r.position == 1) begin
						n        = head_ptr;
						head_ptr = node_nxt[n];
					end else begin
						p           = node_at(r.position - 1'b1);
						n           = node_nxt[p];
						node_nxt[p] = node_nxt[n];
					end
					if (r.position == elem_cnt)
						tail_ptr = p;
					d           = node_val[n];
					node_nxt[n] = free_ptr;
					free_ptr    = n;
					elem_cnt--;
					if (elem_cnt == 0) begin
						head_ptr = '0;
						tail_ptr = '0;
					end
				end
			end
			CMD_PUSH: begin
				if (full) begin
					st = ST_FULL;
				end else begin
					n           = claim_node(r.value);
					node_nxt[n] = head_ptr;
					if (elem_cnt == 0)
						tail_ptr = n;
					head_ptr = n;
					elem_cnt++;
				end
			end
			CMD_APPEND: begin
				if (full) begin
					st = ST_FULL;
				end else begin
					n = claim_node(r.value);
					if (elem_cnt == 0)
						head_ptr = n;
					else
						node_nxt[tail_ptr] = n;
					tail_ptr = n;
					elem_cnt++;
				end
			end
			CMD_CLEAR: rebuild_free_chain();
			default: ;
		endcase
		a.status = st;
		a.data   = d;
		a.count  = elem_cnt;
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: response %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			answer_q.delete();
			rebuild_free_chain();
			mismatch_count = 0;
			answers_due    = 0;
			list_len       = '0;
		end else begin
			// retire first: a response never shares an edge with its own command
			if (done) begin
				if (answer_q.size() == 0) begin
					report_mismatch("with no command outstanding, data", result.data, '0);
				end else begin
					due_now = answer_q.pop_front();
					if (result.status !== due_now.status)
						report_mismatch("status", 32'(result.status), 32'(due_now.status));
					if (result.data !== due_now.data)
						report_mismatch("data", result.data, due_now.data);
					if (result.count !== due_now.count)
						report_mismatch("count", 32'(result.count), 32'(due_now.count));
				end
			end
			if (start && !busy) begin
				run_list_command(request, fresh);
				answer_q.push_back(fresh);
			end
			answers_due = answer_q.size();
			list_len    = elem_cnt;
		end
	end

endmodule

// ===== tb/sv/positional_linked_list_engine_core_tb.sv =====
// Testbench top for the positional linked-list engine: clock, reset, command
// stimulus, watchdog and verdict. Depends on plle_pkg, the engine core and
// positional_linked_list_engine_core_chk.
module positional_linked_list_engine_core_tb;
	import plle_pkg::*;

	// command codes the engine must treat as no-ops
	localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

	localparam int RANDOM_ITEMS = 525;
	// drain well past the longest command at the end
	localparam int DRAIN_CYCLES = 150;
	// worst quiet stretch: the longest command or the longest sender gap
	localparam int STALL_LIMIT  = 2000;

	typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIXED} traffic_mode_t;

	logic       clk     = 1'b0;
	logic       arst_n  = 1'b0;
	logic       start   = 1'b0;
	plle_req_t  request = '0;
	logic       busy;
	logic       done;
	plle_rsp_t  result;

	int unsigned      mismatch_count;
	int unsigned      answers_due;
	logic [CNT_W-1:0] list_len;

	int unsigned quiet_cycles = 0;
	int          burst_left   = 0;

	always #5 clk = ~clk;

	positional_linked_list_engine_core i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.request (request),
		.busy    (busy),
		.done    (done),
		.result  (result)
	);

	positional_linked_list_engine_core_chk i_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.request        (request),
		.done           (done),
		.result         (result),
		.mismatch_count (mismatch_count),
		.answers_due    (answers_due),
		.list_len       (list_len)
	);

	// Watchdog: any edge with a transaction on either channel restarts the
	// count; a hung engine or a lost response runs it out.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("positional_linked_list_engine_core_tb NOT OK");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Sender pacing: bursts of back-to-back commands, then a gap. Gap lengths
	// are random so they land anywhere inside a command's busy window,
	// including the cycle right after done. Long bursts give idle-free runs.
	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			case ($urandom_range(0, 19))
				0:       gap = $urandom_range(31, 90);
				1, 2, 3, 4, 5: gap = $urandom_range(5, 30);
				default: gap = $urandom_range(1, 4);
			endcase
			start <= 1'b0;
			repeat (gap) @(negedge clk);
			burst_left = ($urandom_range(0, 6) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 10);
		end
	endtask

	// Drive one command from a falling edge, hold it until the engine takes
	// it (start high, busy low at a rising edge), return on the next falling
	// edge. start stays high so back-to-back commands need no re-arm.
	task automatic issue(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
			input logic signed [VALUE_BITS-1:0] val);
		plle_req_t r;
		r.command  = cmd;
		r.position = pos;
		r.value    = val;
		pace();
		start   <= 1'b1;
		request <= r;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	function automatic logic signed [VALUE_BITS-1:0] pick_value();
		case ($urandom_range(0, 11))
			0:       return 32'h8000_0000;
			1:       return 32'h7fff_ffff;
			2:       return '0;
			3:       return '1;
			default: return $urandom;
		endcase
	endfunction

	// Mostly in-range positions, with the ends of the list, zero, and
	// anything up to the top of the 7-bit field sprinkled in.
	function automatic logic [POS_W-1:0] pick_position(input logic [CNT_W-1:0] len);
		case ($urandom_range(0, 19))
			0:       return '0;
			1:       return POS_W'($urandom_range(127, int'(len) + 1));
			2:       return POS_W'(1);
			3:       return POS_W'(len);
			default: return (len == 0) ? POS_W'($urandom_range(0, 2))
				: POS_W'($urandom_range(1, int'(len)));
		endcase
	endfunction

	function automatic logic [CMD_W-1:0] pick_command(input traffic_mode_t mode);
		int r;
		r = $urandom_range(0, 99);
		case (mode)
			MODE_GROW: begin
				if (r < 30)      return CMD_PUSH;
				else if (r < 60) return CMD_APPEND;
				else if (r < 88) return CMD_INSERT;
				else if (r < 96) return CMD_GET;
				else             return CMD_DELETE;
			end
			MODE_SHRINK: begin
				if (r < 58)      return CMD_DELETE;
				else if (r < 82) return CMD_GET;
				else if (r < 89) return CMD_PUSH;
				else if (r < 95) return CMD_APPEND;
				else             return CMD_INSERT;
			end
			default: begin
				if (r < 20)      return CMD_GET;
				else if (r < 36) return CMD_INSERT;
				else if (r < 54) return CMD_DELETE;
				else if (r < 68) return CMD_PUSH;
				else if (r < 82) return CMD_APPEND;
				else if (r < 94) return CMD_GET;
				else if (r < 97) return CMD_CLEAR;
				else if (r < 99) return CMD_SPARE_6;
				else             return CMD_SPARE_7;
			end
		endcase
	endfunction

	initial begin
		traffic_mode_t    mode;
		int               span;
		int               random_sent;
		logic [CMD_W-1:0] cmd;

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// --- directed ---
		// empty list: every positional command is out of range,
		// insert included since it never adds to an empty list
		issue(CMD_GET,    1, 32'sd0);
		issue(CMD_INSERT, 1, 32'sd11);
		issue(CMD_DELETE, 1, 32'sd0);
		// build [0, min, max, -1] from both ends
		issue(CMD_PUSH,   0, 32'h8000_0000);
		issue(CMD_APPEND, 0, 32'h7fff_ffff);
		issue(CMD_PUSH,   127, 32'h0000_0000);
		issue(CMD_APPEND, 64, 32'hffff_ffff);
		// position zero, the tail, one past it, top of the field
		issue(CMD_GET,    0, 32'sd0);
		issue(CMD_GET,    4, 32'sd0);
		issue(CMD_GET,    5, 32'sd0);
		issue(CMD_GET,    127, 32'h7fff_ffff);
		// insert at the head, just before the tail, and past the end
		issue(CMD_INSERT, 1, 32'ha5a5_5a5a);
		issue(CMD_INSERT, 5, 32'sd1);
		issue(CMD_INSERT, 7, 32'sd2);
		// remove the tail, then append to prove the tail pointer moved back
		issue(CMD_DELETE, 6, 32'sd0);
		issue(CMD_APPEND, 0, 32'h1234_5678);
		// remove the head and a middle node
		issue(CMD_DELETE, 1, 32'sd0);
		issue(CMD_DELETE, 3, 32'sd0);
		issue(CMD_GET,    2, 32'sd0);
		// spare opcodes change nothing
		issue(CMD_SPARE_6, 1, 32'sd3);
		issue(CMD_SPARE_7, 2, 32'sd4);
		// clear, reuse, drain to empty, reuse again
		issue(CMD_CLEAR,  0, 32'sd0);
		issue(CMD_APPEND, 1, 32'sd7);
		issue(CMD_DELETE, 1, 32'sd0);
		issue(CMD_PUSH,   0, -32'sd5);

		// --- random ---
		// The first span grows hard enough to hit a full store; later spans
		// pick growth, draining or a mix that includes clear at random.
		random_sent = 0;
		mode        = MODE_GROW;
		span        = 110;
		while (random_sent < RANDOM_ITEMS) begin
			for (int k = 0; k < span && random_sent < RANDOM_ITEMS; k++) begin
				cmd = pick_command(mode);
				issue(cmd, pick_position(list_len), pick_value());
				if (cmd != CMD_SPARE_6 && cmd != CMD_SPARE_7)
					random_sent++;
			end
			mode = traffic_mode_t'($urandom_range(0, 2));
			span = (mode == MODE_SHRINK) ? $urandom_range(30, 110) : $urandom_range(15, 70);
		end

		// --- wind down ---
		start <= 1'b0;
		while (answers_due != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0)
			$display("positional_linked_list_engine_core_tb OK");
		else
			$display("positional_linked_list_engine_core_tb NOT OK");
		$finish;
	end

endmodule
